// ===== sv/sle_pkg.sv =====
package sle_pkg;

   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;

   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REM_FIRST = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REM_LAST  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REM_AT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CMP,
      ST_SRCH_STEP,
      ST_SRCH_CMP,
      ST_SRCH_CHK,
      ST_RM_READ,
      ST_RM_WRITE
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT,
      PTR_ZERO,
      PTR_POS,
      PTR_DEC,
      PTR_INC,
      PTR_MID1
   } ptr_op_type;

   typedef enum logic [1:0] {
      HI_HOLD,
      HI_COUNT,
      HI_MID
   } hi_op_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_PREV,
      RD_NEXT,
      RD_MID,
      RD_PTR
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_VALUE,
      WR_RDATA
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef struct packed {
      logic       load;
      ptr_op_type ptr_op;
      hi_op_type  hi_op;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       finish;
      logic       ok;
      logic       found_en;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic ptr_zero;
      logic pos_valid;
      logic next_in;
      logic lo_lt_hi;
      logic lo_lt_count;
      logic rd_gt_value;
      logic rd_lt_value;
      logic rd_eq_value;
   } status_type;

endpackage

// ===== sv/sorted_list_engine_top.sv =====
// Clear, remove-last, unused codes and refused items finish straight from idle. Insert moves
// every entry larger than the value up one slot and writes the value into the gap; remove
// moves the entries after pos down one slot (pos 1 for remove-first); search is a binary
// search over one registered read port.
// One item at a time: the next item can be taken at the edge that takes the result.
// The receiver cannot stall. Reset empties the list; stored entries are not cleared.
module sorted_list_engine_top import sle_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic        [MODE_W-1:0]  req_mode,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic        [POS_W-1:0]   req_position,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic        [POS_W-1:0]   rsp_found_position,
   output logic        [POS_W-1:0]   rsp_count,
   output logic                      rsp_full_res,
   output logic                      rsp_empty_res
);

   cmd_type    cmd;
   status_type status;

   sle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   sle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_value),
      .req_position       (req_position),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_full_res       (rsp_full_res),
      .rsp_empty_res      (rsp_empty_res)
   );

endmodule

// ===== sv/sle_ctrl.sv =====
module sle_ctrl import sle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MODE_W-1:0] req_mode,
   input  status_type        status,
   output logic              busy,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_INSERT:    if (!status.full) state_in = ST_INS_READ;
                  MODE_SEARCH:    state_in = ST_SRCH_STEP;
                  MODE_REM_FIRST: if (!status.empty) state_in = ST_RM_READ;
                  MODE_REM_AT:    if (status.pos_valid) state_in = ST_RM_READ;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_READ: begin
            state_in = status.ptr_zero ? ST_IDLE : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = status.rd_gt_value ? ST_INS_READ : ST_IDLE;
         end
         ST_SRCH_STEP: begin
            priority if (status.lo_lt_hi)    state_in = ST_SRCH_CMP;
            else if     (status.lo_lt_count) state_in = ST_SRCH_CHK;
            else                             state_in = ST_IDLE;
         end
         ST_SRCH_CMP: begin
            state_in = ST_SRCH_STEP;
         end
         ST_SRCH_CHK: begin
            state_in = ST_IDLE;
         end
         ST_RM_READ: begin
            state_in = status.next_in ? ST_RM_WRITE : ST_IDLE;
         end
         ST_RM_WRITE: begin
            state_in = ST_RM_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.ptr_op   = PTR_HOLD;
      cmd.hi_op    = HI_HOLD;
      cmd.rd_sel   = RD_NONE;
      cmd.wr_sel   = WR_NONE;
      cmd.cnt_op   = CNT_HOLD;
      busy         = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_INSERT: begin
                     if (status.full) begin
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.ptr_op = PTR_COUNT;
                     end
                  end
                  MODE_SEARCH: begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.hi_op  = HI_COUNT;
                  end
                  MODE_REM_FIRST: begin
                     if (status.empty) begin
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.ptr_op = PTR_ZERO;
                     end
                  end
                  MODE_REM_LAST: begin
                     cmd.finish = 1'b1;
                     if (!status.empty) begin
                        cmd.ok     = 1'b1;
                        cmd.cnt_op = CNT_DEC;
                     end
                  end
                  MODE_REM_AT: begin
                     if (status.pos_valid) begin
                        cmd.ptr_op = PTR_POS;
                     end else begin
                        cmd.finish = 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     cmd.finish = 1'b1;
                     cmd.ok     = 1'b1;
                     cmd.cnt_op = CNT_CLEAR;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         ST_INS_READ: begin
            if (status.ptr_zero) begin
               cmd.wr_sel = WR_VALUE;
               cmd.cnt_op = CNT_INC;
               cmd.finish = 1'b1;
               cmd.ok     = 1'b1;
            end else begin
               cmd.rd_sel = RD_PREV;
            end
         end
         ST_INS_CMP: begin
            if (status.rd_gt_value) begin
               // move the larger entry up one slot
               cmd.wr_sel = WR_RDATA;
               cmd.ptr_op = PTR_DEC;
            end else begin
               cmd.wr_sel = WR_VALUE;
               cmd.cnt_op = CNT_INC;
               cmd.finish = 1'b1;
               cmd.ok     = 1'b1;
            end
         end
         ST_SRCH_STEP: begin
            priority if (status.lo_lt_hi) begin
               cmd.rd_sel = RD_MID;
            end else if (status.lo_lt_count) begin
               cmd.rd_sel = RD_PTR;
            end else begin
               cmd.finish = 1'b1;
            end
         end
         ST_SRCH_CMP: begin
            if (status.rd_lt_value) begin
               cmd.ptr_op = PTR_MID1;
            end else begin
               cmd.hi_op = HI_MID;
            end
         end
         ST_SRCH_CHK: begin
            cmd.finish = 1'b1;
            if (status.rd_eq_value) begin
               cmd.ok       = 1'b1;
               cmd.found_en = 1'b1;
            end
         end
         ST_RM_READ: begin
            if (status.next_in) begin
               cmd.rd_sel = RD_NEXT;
            end else begin
               cmd.cnt_op = CNT_DEC;
               cmd.finish = 1'b1;
               cmd.ok     = 1'b1;
            end
         end
         ST_RM_WRITE: begin
            // close the gap
            cmd.wr_sel = WR_RDATA;
            cmd.ptr_op = PTR_INC;
         end
         default: begin
            cmd.finish = 1'b0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_busy_ends_on_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(cmd.finish))
      else $error("busy dropped without a finished item");

   a_rdata_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_RDATA) |-> $past(cmd.rd_sel != RD_NONE))
      else $error("shift write without a preceding read");

   a_idle_no_memory_access: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cmd.rd_sel == RD_NONE && cmd.wr_sel == WR_NONE))
      else $error("memory access while idle");
`endif

endmodule

// ===== sv/sle_datapath.sv =====
module sle_datapath import sle_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic        [POS_W-1:0]   req_position,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic        [POS_W-1:0]   rsp_found_position,
   output logic        [POS_W-1:0]   rsp_count,
   output logic                      rsp_full_res,
   output logic                      rsp_empty_res
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   logic        [CW-1:0]      count_ff, count_in;
   logic        [CW-1:0]      ptr_ff, ptr_in;
   logic        [CW-1:0]      hi_ff, hi_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] rdata_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_ok_ff;
   logic        [POS_W-1:0]   rsp_found_ff;
   logic        [POS_W-1:0]   rsp_count_ff;
   logic                      rsp_full_ff;
   logic                      rsp_empty_ff;

   logic        [CW:0]        mid_sum;
   logic        [CW-1:0]      mid;
   logic        [XW-1:0]      pos_m1;
   logic        [CW-1:0]      rd_ptr;
   logic        [CW:0]        ptr_p1_wide;
   logic        [XW-1:0]      found_x;
   logic        [XW-1:0]      count_x;
   logic signed [VALUE_W-1:0] wr_data;

   assign mid_sum     = {1'b0, ptr_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[CW:1];
   assign pos_m1      = XW'(req_position) - XW'(1);
   assign ptr_p1_wide = {1'b0, ptr_ff} + (CW+1)'(1);

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_COUNT: ptr_in = count_ff;
         PTR_ZERO:  ptr_in = '0;
         PTR_POS:   ptr_in = pos_m1[CW-1:0];
         PTR_DEC:   ptr_in = ptr_ff - CW'(1);
         PTR_INC:   ptr_in = ptr_ff + CW'(1);
         PTR_MID1:  ptr_in = mid + CW'(1);
         default:   ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.hi_op)
         HI_HOLD:  hi_in = hi_ff;
         HI_COUNT: hi_in = count_ff;
         HI_MID:   hi_in = mid;
         default:  hi_in = hi_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_ptr = ptr_ff - CW'(1);
         RD_NEXT: rd_ptr = ptr_p1_wide[CW-1:0];
         RD_MID:  rd_ptr = mid;
         default: rd_ptr = ptr_ff;
      endcase
   end

   assign wr_data = (cmd.wr_sel == WR_RDATA) ? rdata_ff : value_ff;
   assign found_x = XW'(ptr_ff) + XW'(1);
   assign count_x = XW'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.wr_sel != WR_NONE) begin
         mem[ptr_ff[IW-1:0]] <= wr_data;
      end
      if (cmd.rd_sel != RD_NONE) begin
         rdata_ff <= mem[rd_ptr[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      hi_ff  <= hi_in;
      if (cmd.load) begin
         value_ff <= req_value;
      end
      if (cmd.finish) begin
         rsp_ok_ff    <= cmd.ok;
         rsp_found_ff <= cmd.found_en ? found_x[POS_W-1:0] : '0;
         rsp_count_ff <= count_x[POS_W-1:0];
         rsp_full_ff  <= (count_in == CW'(CAPACITY));
         rsp_empty_ff <= (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_comb begin
      status.full        = (count_ff == CW'(CAPACITY));
      status.empty       = (count_ff == '0);
      status.ptr_zero    = (ptr_ff == '0);
      status.pos_valid   = (req_position != '0) && (XW'(req_position) <= XW'(count_ff));
      status.next_in     = (ptr_p1_wide < {1'b0, count_ff});
      status.lo_lt_hi    = (ptr_ff < hi_ff);
      status.lo_lt_count = (ptr_ff < count_ff);
      status.rd_gt_value = (rdata_ff > value_ff);
      status.rd_lt_value = (rdata_ff < value_ff);
      status.rd_eq_value = (rdata_ff == value_ff);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_full_res       = rsp_full_ff;
   assign rsp_empty_res      = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel != WR_NONE) |-> (ptr_ff < CW'(CAPACITY) && ptr_ff <= count_ff))
      else $error("write outside the list");

   a_found_implies_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_position != '0) |-> rsp_ok)
      else $error("match position reported on a failed item");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import sle_pkg::*;

   localparam int CAPACITY      = 64;
   localparam int ITEM_TARGET   = 1000;
   localparam int SETTLE_CYCLES = 200;

   localparam logic [MODE_W-1:0] MODE_UNUSED6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] found_position;
      logic [POS_W-1:0] count;
      logic             full;
      logic             empty;
   } list_result_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      logic                      typed;
      list_result_type           result;
   } directed_row_type;

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_LOOKUP} segment_kind_type;

   localparam list_result_type RES_EMPTY_FAIL = '{1'b0, 7'd0, 7'd0, 1'b0, 1'b1};
   localparam list_result_type RES_CLEARED    = '{1'b1, 7'd0, 7'd0, 1'b0, 1'b1};
   localparam list_result_type RES_FIVE_FAIL  = '{1'b0, 7'd0, 7'd5, 1'b0, 1'b0};

   // typed rows carry their result; the rest go through the list predictor
   directed_row_type directed_rows [24] = '{
      '{MODE_SEARCH,    32'sd0,    7'd0,   1'b1, RES_EMPTY_FAIL},
      '{MODE_REM_FIRST, 32'sd0,    7'd0,   1'b1, RES_EMPTY_FAIL},
      '{MODE_REM_LAST,  32'sd0,    7'd0,   1'b1, RES_EMPTY_FAIL},
      '{MODE_REM_AT,    32'sd0,    7'd1,   1'b1, RES_EMPTY_FAIL},
      '{MODE_UNUSED6,   -32'sd1,   7'd127, 1'b1, RES_EMPTY_FAIL},
      '{MODE_UNUSED7,   VALUE_MAX, 7'd64,  1'b1, RES_EMPTY_FAIL},
      '{MODE_CLEAR,     32'sd0,    7'd0,   1'b1, RES_CLEARED},
      '{MODE_INSERT,    VALUE_MIN, 7'd0,   1'b1, '{1'b1, 7'd0, 7'd1, 1'b0, 1'b0}},
      '{MODE_INSERT,    VALUE_MAX, 7'd0,   1'b1, '{1'b1, 7'd0, 7'd2, 1'b0, 1'b0}},
      '{MODE_INSERT,    32'sd0,    7'd0,   1'b0, '0},
      '{MODE_INSERT,    32'sd0,    7'd0,   1'b0, '0},
      '{MODE_INSERT,    -32'sd1,   7'd0,   1'b0, '0},
      '{MODE_SEARCH,    32'sd0,    7'd0,   1'b0, '0},
      '{MODE_SEARCH,    VALUE_MIN, 7'd0,   1'b0, '0},
      '{MODE_SEARCH,    VALUE_MAX, 7'd0,   1'b0, '0},
      '{MODE_SEARCH,    32'sd7,    7'd0,   1'b0, '0},
      '{MODE_REM_AT,    32'sd0,    7'd0,   1'b1, RES_FIVE_FAIL},
      '{MODE_REM_AT,    32'sd0,    7'd6,   1'b1, RES_FIVE_FAIL},
      '{MODE_REM_AT,    32'sd0,    7'd127, 1'b1, RES_FIVE_FAIL},
      '{MODE_REM_AT,    32'sd0,    7'd3,   1'b0, '0},
      '{MODE_UNUSED6,   32'sd0,    7'd0,   1'b0, '0},
      '{MODE_REM_FIRST, 32'sd0,    7'd0,   1'b0, '0},
      '{MODE_REM_LAST,  32'sd0,    7'd0,   1'b0, '0},
      '{MODE_CLEAR,     32'sd0,    7'd0,   1'b1, RES_CLEARED}
   };

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic        [MODE_W-1:0]  req_mode = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic        [POS_W-1:0]   req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ok;
   logic        [POS_W-1:0]   rsp_found_position;
   logic        [POS_W-1:0]   rsp_count;
   logic                      rsp_full_res;
   logic                      rsp_empty_res;

   // result to use in place of the prediction for typed rows
   logic                      req_typed = 1'b0;
   list_result_type           req_typed_res = '0;

   logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
   int                        shadow_len = 0;
   list_result_type           expected_results [$];
   int                        mismatch_count = 0;
   int                        burst_left = 1;

   sorted_list_engine_top #(.CAPACITY(CAPACITY)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_full_res       (rsp_full_res),
      .rsp_empty_res      (rsp_empty_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("FAILURE");
      $finish;
   end

   function automatic void drop_entry(input int idx);
      for (int i = idx; i + 1 < shadow_len; i++)
         shadow_entries[i] = shadow_entries[i + 1];
      shadow_len--;
   endfunction

   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic signed [VALUE_W-1:0] value,
                                                     input logic [POS_W-1:0] position);
      list_result_type res;
      int              slot;
      bit              done;
      res = '0;
      case (mode)
         MODE_INSERT: begin
            if (shadow_len < CAPACITY) begin
               // shift larger entries up; equal ones stay ahead of the new value
               slot = shadow_len;
               while (slot > 0 && shadow_entries[slot - 1] > value) begin
                  shadow_entries[slot] = shadow_entries[slot - 1];
                  slot--;
               end
               shadow_entries[slot] = value;
               shadow_len++;
               res.ok = 1'b1;
            end
         end
         MODE_SEARCH: begin
            done = 1'b0;
            for (int i = 0; i < shadow_len && !done; i++) begin
               if (shadow_entries[i] == value) begin
                  res.found_position = POS_W'(i + 1);
                  res.ok = 1'b1;
                  done = 1'b1;
               end else if (shadow_entries[i] > value) begin
                  done = 1'b1;
               end
            end
         end
         MODE_REM_FIRST: begin
            if (shadow_len > 0) begin
               drop_entry(0);
               res.ok = 1'b1;
            end
         end
         MODE_REM_LAST: begin
            if (shadow_len > 0) begin
               shadow_len--;
               res.ok = 1'b1;
            end
         end
         MODE_REM_AT: begin
            if (position >= 1 && int'(position) <= shadow_len) begin
               drop_entry(int'(position) - 1);
               res.ok = 1'b1;
            end
         end
         MODE_CLEAR: begin
            shadow_len = 0;
            res.ok = 1'b1;
         end
         default: begin
         end
      endcase
      res.count = POS_W'(shadow_len);
      res.full  = (shadow_len == CAPACITY);
      res.empty = (shadow_len == 0);
      return res;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding, expected none, actual count %0d",
                        $time, rsp_count);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               report_field("ok", want.ok, rsp_ok);
               report_field("found_position", want.found_position, rsp_found_position);
               report_field("count", want.count, rsp_count);
               report_field("full", want.full, rsp_full_res);
               report_field("empty", want.empty, rsp_empty_res);
            end
         end
         if (start && !busy) begin
            want = apply_list_op(req_mode, req_value, req_position);
            expected_results.push_back(req_typed ? req_typed_res : want);
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3)
         return VALUE_W'($urandom_range(0, 15)) - 32'sd8;
      if (r <= 5 && shadow_len > 0)
         return shadow_entries[$urandom_range(0, shadow_len - 1)];
      if (r == 6) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 6)
         return (shadow_len > 0) ? POS_W'($urandom_range(1, shadow_len)) : 7'd1;
      if (r == 7)
         return 7'd0;
      if (r == 8)
         return POS_W'(shadow_len + 1);
      return POS_W'($urandom_range(0, 127));
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(input segment_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         SEG_DRAIN: begin
            if (r < 15) return MODE_INSERT;
            if (r < 30) return MODE_SEARCH;
            if (r < 55) return MODE_REM_AT;
            if (r < 72) return MODE_REM_FIRST;
            if (r < 90) return MODE_REM_LAST;
            if (r < 95) return MODE_CLEAR;
         end
         SEG_LOOKUP: begin
            if (r < 25) return MODE_INSERT;
            if (r < 80) return MODE_SEARCH;
            if (r < 90) return MODE_REM_AT;
            if (r < 96) return MODE_REM_FIRST;
         end
         default: begin
            if (r < 40) return MODE_INSERT;
            if (r < 60) return MODE_SEARCH;
            if (r < 72) return MODE_REM_AT;
            if (r < 80) return MODE_REM_FIRST;
            if (r < 88) return MODE_REM_LAST;
            if (r < 92) return MODE_CLEAR;
            if (r < 96) return MODE_INSERT;
         end
      endcase
      return r[0] ? MODE_UNUSED7 : MODE_UNUSED6;
   endfunction

   // present one item, hold it until accepted, then maybe idle between bursts
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position,
                            input logic typed, input list_result_type typed_res);
      int gap;
      start         <= 1'b1;
      req_mode      <= mode;
      req_value     <= value;
      req_position  <= position;
      req_typed     <= typed;
      req_typed_res <= typed_res;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int                counted;
      int                over_full;
      int                seg_items;
      bit                first_segment;
      segment_kind_type  kind;
      logic [MODE_W-1:0] mode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(directed_rows); r++)
         send_item(directed_rows[r].mode, directed_rows[r].value, directed_rows[r].position,
                   directed_rows[r].typed, directed_rows[r].result);

      counted = 0;
      first_segment = 1'b1;
      while (counted < ITEM_TARGET) begin
         kind = first_segment ? SEG_FILL : segment_kind_type'($urandom_range(0, 3));
         if (kind == SEG_FILL) begin
            // fill to capacity, then push a few inserts against the full list
            over_full = 0;
            while (over_full < 3) begin
               mode = ($urandom_range(0, 4) == 0) ? MODE_SEARCH : MODE_INSERT;
               if (mode == MODE_INSERT && shadow_len == CAPACITY)
                  over_full++;
               send_item(mode, pick_value(), pick_position(), 1'b0, '0);
               counted++;
            end
         end else begin
            seg_items = $urandom_range(10, 60);
            repeat (seg_items) begin
               mode = pick_mode(kind);
               if (mode <= MODE_CLEAR)
                  counted++;
               send_item(mode, pick_value(), pick_position(), 1'b0, '0);
            end
         end
         if (first_segment || $urandom_range(0, 4) == 0)
            wait_for_results();
         first_segment = 1'b0;
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
